@@ hdl/ds2fd_pkg.sv @@
package ds2fd_pkg;

  // Frame header constants
  localparam logic [7:0] HDR_LEAD     = 8'hB8;
  localparam logic [7:0] HDR_ADDR_A   = 8'h29;
  localparam logic [7:0] HDR_ADDR_B   = 8'hF1;
  localparam logic [7:0] MAX_LONG_PAY = 8'd250;
  localparam logic [7:0] MIN_SHORT_SZ = 8'd3;
  // Header plus length byte plus checksum byte
  localparam logic [7:0] OVERHEAD_SHORT = 8'd3;
  localparam logic [7:0] OVERHEAD_LONG  = 8'd5;

  typedef enum logic {
    IN_BYTE = 1'b0,
    IN_EOC  = 1'b1
  } in_kind_e;

  typedef enum logic [2:0] {
    RK_PAYLOAD = 3'd0,
    RK_OK      = 3'd1,
    RK_BADSUM  = 3'd2,
    RK_BADLEN  = 3'd3,
    RK_TRUNC   = 3'd4
  } result_kind_e;

  typedef struct packed {
    logic kind;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   pbyte;
    logic [7:0]   pindex;
    logic [7:0]   address;
    logic         long_hdr;
    logic [7:0]   plen;
  } result_t;

  // Payload count implied by a frame size; zero while the size is unknown.
  function automatic logic [7:0] declared_len(input logic [7:0] fsize, input logic long_hdr);
    logic [7:0] ovh;
    ovh = long_hdr ? OVERHEAD_LONG : OVERHEAD_SHORT;
    return (fsize < ovh) ? 8'd0 : (fsize - ovh);
  endfunction

endpackage

@@ hdl/ds2fd_in_stage.sv @@
module ds2fd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ds2fd_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output ds2fd_pkg::item_t item_o
);

  logic             valid_q, valid_d;
  ds2fd_pkg::item_t item_q;
  logic             load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hdl/ds2fd_parser.sv @@
module ds2fd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ds2fd_pkg::item_t   item_i,
  output logic               res_valid_o,
  output ds2fd_pkg::result_t res_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] hdr0_q, hdr0_d;
  logic [7:0] hdr1_q, hdr1_d;
  logic       long_q, long_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] fsize_q, fsize_d;
  logic       disc_q, disc_d;

  logic [7:0] b;
  logic       cand;
  logic       lng;
  logic [7:0] fs_eff;
  logic       frame_end;
  logic       good;

  assign b = item_i.value;

  always_comb begin
    pos_d   = pos_q;
    hdr0_d  = hdr0_q;
    hdr1_d  = hdr1_q;
    long_d  = long_q;
    xor_d   = xor_q;
    fsize_d = fsize_q;
    disc_d  = disc_q;
    res_valid_o    = 1'b0;
    res_o.kind     = ds2fd_pkg::RK_PAYLOAD;
    res_o.pbyte    = 8'd0;
    res_o.pindex   = 8'd0;
    res_o.address  = hdr0_q;
    res_o.long_hdr = long_q;
    res_o.plen     = ds2fd_pkg::declared_len(fsize_q, long_q);
    cand      = (hdr0_q == ds2fd_pkg::HDR_LEAD) &&
                ((b == ds2fd_pkg::HDR_ADDR_A) || (b == ds2fd_pkg::HDR_ADDR_B));
    lng       = ((hdr1_q == ds2fd_pkg::HDR_ADDR_A) && (b == ds2fd_pkg::HDR_ADDR_B)) ||
                ((hdr1_q == ds2fd_pkg::HDR_ADDR_B) && (b == ds2fd_pkg::HDR_ADDR_A));
    fs_eff    = ((pos_q == 8'd2) && (fsize_q == 8'd0)) ? hdr1_q : fsize_q;
    frame_end = ({1'b0, pos_q} + 9'd1) >= {1'b0, fs_eff};
    good      = (xor_q == b);

    if (item_i.kind == ds2fd_pkg::IN_EOC) begin
      // end of capture: report a partial frame, then start clean
      res_valid_o = !disc_q && (pos_q != 8'd0);
      res_o.kind  = ds2fd_pkg::RK_TRUNC;
      pos_d   = 8'd0;
      long_d  = 1'b0;
      xor_d   = 8'd0;
      fsize_d = 8'd0;
      disc_d  = 1'b0;
    end else if (!disc_q) begin
      if (pos_q == 8'd0) begin
        hdr0_d = b;
        xor_d  = b;
        pos_d  = 8'd1;
      end else if (pos_q == 8'd1) begin
        hdr1_d = b;
        xor_d  = xor_q ^ b;
        pos_d  = 8'd2;
        if (!cand) begin
          if (b < ds2fd_pkg::MIN_SHORT_SZ) begin
            res_valid_o = 1'b1;
            res_o.kind  = ds2fd_pkg::RK_BADLEN;
            res_o.plen  = b;
            pos_d   = 8'd0;
            xor_d   = 8'd0;
            fsize_d = 8'd0;
            disc_d  = 1'b1;
          end else begin
            fsize_d = b;
          end
        end
      end else if ((pos_q == 8'd2) && (fsize_q == 8'd0) && lng) begin
        long_d = 1'b1;
        xor_d  = xor_q ^ b;
        pos_d  = 8'd3;
      end else if (long_q && (pos_q == 8'd3)) begin
        // length byte of a long-header frame counts payload only
        if (b > ds2fd_pkg::MAX_LONG_PAY) begin
          res_valid_o = 1'b1;
          res_o.kind  = ds2fd_pkg::RK_BADLEN;
          res_o.plen  = b;
          pos_d   = 8'd0;
          long_d  = 1'b0;
          xor_d   = 8'd0;
          fsize_d = 8'd0;
          disc_d  = 1'b1;
        end else begin
          xor_d   = xor_q ^ b;
          fsize_d = b + ds2fd_pkg::OVERHEAD_LONG;
          pos_d   = 8'd4;
        end
      end else begin
        res_valid_o = 1'b1;
        res_o.plen  = ds2fd_pkg::declared_len(fs_eff, long_q);
        if (frame_end) begin
          // checksum byte closes the frame
          res_o.kind = good ? ds2fd_pkg::RK_OK : ds2fd_pkg::RK_BADSUM;
          pos_d   = 8'd0;
          long_d  = 1'b0;
          xor_d   = 8'd0;
          fsize_d = 8'd0;
          disc_d  = !good;
        end else begin
          res_o.pbyte  = b;
          res_o.pindex = pos_q - (long_q ? 8'd4 : 8'd2);
          xor_d   = xor_q ^ b;
          pos_d   = pos_q + 8'd1;
          fsize_d = fs_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 8'd0;
      hdr0_q  <= 8'd0;
      hdr1_q  <= 8'd0;
      long_q  <= 1'b0;
      xor_q   <= 8'd0;
      fsize_q <= 8'd0;
      disc_q  <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      hdr0_q  <= hdr0_d;
      hdr1_q  <= hdr1_d;
      long_q  <= long_d;
      xor_q   <= xor_d;
      fsize_q <= fsize_d;
      disc_q  <= disc_d;
    end
  end

endmodule

@@ hdl/ds2fd_out_stage.sv @@
module ds2fd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               res_valid_i,
  input  ds2fd_pkg::result_t res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output ds2fd_pkg::result_t res_o
);

  logic               valid_q, valid_d;
  ds2fd_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (step_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ hdl/ds2fd_frame_deframer.sv @@
// Path: a request passes through the input register, then one pass of parse logic, and
//   its result lands in the result register.
// Throughput: one request per cycle; the only stall is a held result register.
// Reset: rst_ni is asynchronous, active low; it empties both stages and clears
//   the frame state (position, checksum, size, drop mode) at once.
module ds2_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] address_byte_o,
  output logic       long_header_o,
  output logic [7:0] payload_length_o
);

  ds2fd_pkg::item_t   in_item;
  ds2fd_pkg::item_t   held_item;
  logic               held_valid;
  logic               step;
  logic               res_valid;
  ds2fd_pkg::result_t res;
  ds2fd_pkg::result_t out_res;

  assign in_item.kind  = kind_i;
  assign in_item.value = byte_value_i;

  // Advance the held request whenever the result register is free or being
  // drained this cycle; a request that yields no result still needs the slot
  // so ordering stays simple.
  assign step = held_valid && (!out_valid_o || out_ready_i);

  ds2fd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // Parse one byte against the frame state: header detection, length checks,
  // running XOR and payload indexing all happen in this single pass.
  ds2fd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the finished result until the downstream side takes it.
  ds2fd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign result_kind_o    = out_res.kind;
  assign payload_byte_o   = out_res.pbyte;
  assign payload_index_o  = out_res.pindex;
  assign address_byte_o   = out_res.address;
  assign long_header_o    = out_res.long_hdr;
  assign payload_length_o = out_res.plen;

endmodule

@@ tb/ds2_frame_deframer_tb.sv @@
`timescale 1ns / 100ps

module ds2_frame_deframer_tb;

  // Stop the random part after this many requests that the block acts on.
  localparam int RANDOM_REQUESTS = 1250;
  // Give up well past the slowest legal run (about 2000 requests, each with a
  // long sender gap and a long receiver stall).
  localparam int CYCLE_LIMIT     = 200000;
  // Two-stage pipeline; leave generous room for a stray late result.
  localparam int TAIL_CYCLES     = 20;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    ds2fd_pkg::in_kind_e kind;
    logic [7:0]          value;
    bit                  typed;
    ds2fd_pkg::result_t  want;
  } stim_row_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic       kind_i       = 1'b0;
  logic [7:0] byte_value_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [2:0] result_kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] payload_index_o;
  logic [7:0] address_byte_o;
  logic       long_header_o;
  logic [7:0] payload_length_o;

  // Deframer state as the block should hold it.
  logic [8:0] fr_pos;
  logic [7:0] fr_head [3];
  logic       fr_long;
  logic [7:0] fr_xor;
  logic [8:0] fr_size;
  logic       fr_drop;

  ds2fd_pkg::result_t pending_results [$];
  stim_row_t          directed_rows [$];
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         live_requests = 0;
  int         sent_requests = 0;
  int         results_checked = 0;
  int         mismatches    = 0;
  int         cycle_count   = 0;
  int         kinds_seen [5];

  ds2_frame_deframer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .byte_value_i     (byte_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .address_byte_o   (address_byte_o),
    .long_header_o    (long_header_o),
    .payload_length_o (payload_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop if the block hangs or loses results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result side at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_frame();
    fr_pos  = '0;
    fr_head = '{default: 8'h00};
    fr_long = 1'b0;
    fr_xor  = 8'h00;
    fr_size = '0;
  endfunction

  // Payload count declared by the length byte; zero while the size is unknown.
  function automatic logic [7:0] declared_payload_count();
    logic [8:0] overhead;
    overhead = fr_long ? 9'd5 : 9'd3;
    return (fr_size < overhead) ? 8'h00 : 8'(fr_size - overhead);
  endfunction

  function automatic ds2fd_pkg::result_t frame_result(input ds2fd_pkg::result_kind_e kind,
                                                      input logic [7:0] pbyte,
                                                      input logic [7:0] pindex,
                                                      input logic [7:0] plen);
    ds2fd_pkg::result_t r;
    r.kind     = kind;
    r.pbyte    = pbyte;
    r.pindex   = pindex;
    r.address  = fr_head[0];
    r.long_hdr = fr_long;
    r.plen     = plen;
    return r;
  endfunction

  // Advance the deframer by one request; return 1 when it yields a result.
  function automatic bit deframe_step(input ds2fd_pkg::in_kind_e kind, input logic [7:0] b,
                                      output ds2fd_pkg::result_t r);
    logic [8:0] pos;
    int         hdr_len;
    bit         candidate;
    bit         good;
    pos = fr_pos;
    r   = '0;
    if (kind == ds2fd_pkg::IN_EOC) begin
      // A frame cut short reports truncation; between frames the capture
      // end only clears the state.
      good = !fr_drop && pos != 0;
      if (good) r = frame_result(ds2fd_pkg::RK_TRUNC, 8'h00, 8'h00, declared_payload_count());
      clear_frame();
      fr_drop = 1'b0;
      return good;
    end
    if (fr_drop) return 1'b0;

    if (pos < 3) fr_head[pos] = b;

    if (pos == 0) begin
      fr_xor = b;
      fr_pos = 9'd1;
      return 1'b0;
    end

    if (pos == 1) begin
      candidate = fr_head[0] == ds2fd_pkg::HDR_LEAD &&
                  (b == ds2fd_pkg::HDR_ADDR_A || b == ds2fd_pkg::HDR_ADDR_B);
      fr_xor ^= b;
      fr_pos = 9'd2;
      if (!candidate) begin
        if (b < ds2fd_pkg::MIN_SHORT_SZ) begin
          r = frame_result(ds2fd_pkg::RK_BADLEN, 8'h00, 8'h00, b);
          clear_frame();
          fr_drop = 1'b1;
          return 1'b1;
        end
        fr_size = {1'b0, b};
      end
      return 1'b0;
    end

    // Third byte of a b8 29/f1 start: complete the long header or fall back
    // to a one-byte address whose length byte was the second byte.
    if (pos == 2 && fr_size == 0) begin
      if ((fr_head[1] == ds2fd_pkg::HDR_ADDR_A && b == ds2fd_pkg::HDR_ADDR_B) ||
          (fr_head[1] == ds2fd_pkg::HDR_ADDR_B && b == ds2fd_pkg::HDR_ADDR_A)) begin
        fr_long = 1'b1;
        fr_xor ^= b;
        fr_pos = 9'd3;
        return 1'b0;
      end
      fr_size = {1'b0, fr_head[1]};
    end

    if (fr_long && pos == 3) begin
      fr_xor ^= b;
      if (b > ds2fd_pkg::MAX_LONG_PAY) begin
        r = frame_result(ds2fd_pkg::RK_BADLEN, 8'h00, 8'h00, b);
        clear_frame();
        fr_drop = 1'b1;
        return 1'b1;
      end
      fr_size = b + 9'd5;
      fr_pos  = 9'd4;
      return 1'b0;
    end

    hdr_len = fr_long ? 3 : 1;
    if (pos + 1 >= fr_size) begin
      good = fr_xor == b;
      r = frame_result(good ? ds2fd_pkg::RK_OK : ds2fd_pkg::RK_BADSUM, 8'h00, 8'h00,
                       declared_payload_count());
      clear_frame();
      if (!good) fr_drop = 1'b1;
      return 1'b1;
    end
    fr_xor ^= b;
    fr_pos = pos + 9'd1;
    r = frame_result(ds2fd_pkg::RK_PAYLOAD, b, 8'(pos - hdr_len - 1),
                     declared_payload_count());
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then record what it should
  // produce. A typed expectation replaces the predicted one.
  task automatic send_request(input ds2fd_pkg::in_kind_e kind, input logic [7:0] b,
                              input bit typed, input ds2fd_pkg::result_t want);
    ds2fd_pkg::result_t predicted;
    bit                 has_result;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    byte_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_requests++;
    if (kind == ds2fd_pkg::IN_EOC || !fr_drop) live_requests++;
    has_result = deframe_step(kind, b, predicted);
    if (typed) pending_results.push_back(want);
    else if (has_result) pending_results.push_back(predicted);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void add_row(input ds2fd_pkg::in_kind_e kind, input logic [7:0] value,
                                  input bit typed, input ds2fd_pkg::result_t want);
    stim_row_t row;
    row.kind  = kind;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic ds2fd_pkg::result_t status_of(input ds2fd_pkg::result_kind_e kind,
                                                   input logic [7:0] address,
                                                   input logic long_hdr,
                                                   input logic [7:0] plen);
    ds2fd_pkg::result_t r;
    r.kind     = kind;
    r.pbyte    = 8'h00;
    r.pindex   = 8'h00;
    r.address  = address;
    r.long_hdr = long_hdr;
    r.plen     = plen;
    return r;
  endfunction

  // One random stream fragment: mostly well-formed frames with random content,
  // some corrupted, truncated or with bad lengths, plus stray bytes.
  task automatic send_random_frame();
    logic [7:0] body [$];
    logic [7:0] sum;
    int         style;
    int         n_pay;
    int         cut;
    bit         lng;
    style = $urandom_range(99);

    // Recover from an error: a few dropped bytes, then end of capture.
    if (fr_drop) begin
      repeat ($urandom_range(0, 3)) send_request(ds2fd_pkg::IN_BYTE, 8'($urandom), 1'b0, '0);
      send_request(ds2fd_pkg::IN_EOC, 8'($urandom), 1'b0, '0);
      return;
    end
    if (style < 6) begin
      repeat ($urandom_range(1, 4)) send_request(ds2fd_pkg::IN_BYTE, 8'($urandom), 1'b0, '0);
      return;
    end
    if (style < 12) begin
      send_request(ds2fd_pkg::IN_EOC, 8'($urandom), 1'b0, '0);
      return;
    end

    lng   = style < 40;
    n_pay = ($urandom_range(99) < 2) ? $urandom_range(0, lng ? 250 : 252)
                                     : $urandom_range(0, 8);
    if (lng) begin
      body.push_back(ds2fd_pkg::HDR_LEAD);
      if ($urandom_range(1)) begin
        body.push_back(ds2fd_pkg::HDR_ADDR_A);
        body.push_back(ds2fd_pkg::HDR_ADDR_B);
      end else begin
        body.push_back(ds2fd_pkg::HDR_ADDR_B);
        body.push_back(ds2fd_pkg::HDR_ADDR_A);
      end
      body.push_back(8'(n_pay));
    end else if (style < 47) begin
      // b8 then 29 (rarely f1) as length: the third byte must not complete
      // the long header, so it becomes the first payload byte.
      body.push_back(ds2fd_pkg::HDR_LEAD);
      body.push_back(($urandom_range(9) == 0) ? ds2fd_pkg::HDR_ADDR_B : ds2fd_pkg::HDR_ADDR_A);
      n_pay = body[1] - 3;
    end else begin
      body.push_back(8'($urandom));
      body.push_back(8'(n_pay + 3));
    end

    // Inject a bad length byte now and then.
    if ($urandom_range(99) < 5) begin
      body[body.size() - 1] = lng ? 8'($urandom_range(251, 255)) : 8'($urandom_range(0, 2));
      if (!lng && body[0] == ds2fd_pkg::HDR_LEAD) body[0] = 8'h00;
      n_pay = 0;
    end

    for (int i = 0; i < n_pay; i++) body.push_back(8'($urandom));
    if (!lng && body[0] == ds2fd_pkg::HDR_LEAD && body.size() > 2 &&
        ((body[1] == ds2fd_pkg::HDR_ADDR_A && body[2] == ds2fd_pkg::HDR_ADDR_B) ||
         (body[1] == ds2fd_pkg::HDR_ADDR_B && body[2] == ds2fd_pkg::HDR_ADDR_A)))
      body[2] ^= 8'h01;

    sum = 8'h00;
    foreach (body[i]) sum ^= body[i];
    if ($urandom_range(99) < 8) sum ^= 8'($urandom_range(1, 255));
    body.push_back(sum);

    // Cut the frame short and end the capture inside it.
    cut = ($urandom_range(99) < 8) ? $urandom_range(1, body.size() - 1) : body.size();
    for (int i = 0; i < cut; i++) send_request(ds2fd_pkg::IN_BYTE, body[i], 1'b0, '0);
    if (cut < body.size()) send_request(ds2fd_pkg::IN_EOC, 8'($urandom), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare each result with the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    ds2fd_pkg::result_t got;
    ds2fd_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind     = ds2fd_pkg::result_kind_e'(result_kind_o);
      got.pbyte    = payload_byte_o;
      got.pindex   = payload_index_o;
      got.address  = address_byte_o;
      got.long_hdr = long_header_o;
      got.plen     = payload_length_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result at cycle %0d: kind %0d byte %h idx %0d addr %h %s",
                   cycle_count, got.kind, got.pbyte, got.pindex, got.address,
                   $sformatf("long %b len %0d", got.long_hdr, got.plen));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.kind <= ds2fd_pkg::RK_TRUNC) kinds_seen[got.kind]++;
        if (got.kind !== want.kind || got.pbyte !== want.pbyte || got.pindex !== want.pindex ||
            got.address !== want.address || got.long_hdr !== want.long_hdr ||
            got.plen !== want.plen) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected kind %0d byte %h idx %0d addr %h long %b len %0d",
                     want.kind, want.pbyte, want.pindex, want.address, want.long_hdr, want.plen);
            $display("  actual   kind %0d byte %h idx %0d addr %h long %b len %0d",
                     got.kind, got.pbyte, got.pindex, got.address, got.long_hdr, got.plen);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int start_count;
    int phase;
    int cur_phase;
    clear_frame();
    fr_drop    = 1'b0;
    kinds_seen = '{default: 0};

    // Frame cut after its first byte: length still unknown.
    add_row(ds2fd_pkg::IN_BYTE, 8'h55, 1'b0, '0);
    add_row(ds2fd_pkg::IN_EOC,  8'h00, 1'b1,
            status_of(ds2fd_pkg::RK_TRUNC, 8'h55, 1'b0, 8'd0));
    // Short frame, one payload byte, good checksum.
    add_row(ds2fd_pkg::IN_BYTE, 8'h10, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h04, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'hAA, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'hBE, 1'b1,
            status_of(ds2fd_pkg::RK_OK, 8'h10, 1'b0, 8'd1));
    // Long header b8 29 f1 with an empty payload.
    add_row(ds2fd_pkg::IN_BYTE, 8'hB8, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h29, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'hF1, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h00, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h60, 1'b1,
            status_of(ds2fd_pkg::RK_OK, 8'hB8, 1'b1, 8'd0));
    // Long header b8 f1 29 with a payload count past the limit; drop after.
    add_row(ds2fd_pkg::IN_BYTE, 8'hB8, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'hF1, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h29, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'hFB, 1'b1,
            status_of(ds2fd_pkg::RK_BADLEN, 8'hB8, 1'b1, 8'd251));
    add_row(ds2fd_pkg::IN_BYTE, 8'hFF, 1'b0, '0);
    add_row(ds2fd_pkg::IN_EOC,  8'hFF, 1'b0, '0);
    // Short frame whose length byte is below the minimum.
    add_row(ds2fd_pkg::IN_BYTE, 8'h00, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h02, 1'b1,
            status_of(ds2fd_pkg::RK_BADLEN, 8'h00, 1'b0, 8'd2));
    add_row(ds2fd_pkg::IN_EOC,  8'h00, 1'b0, '0);
    // b8 29 without f1: short frame of size 0x29, cut after first payload byte.
    add_row(ds2fd_pkg::IN_BYTE, 8'hB8, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h29, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h00, 1'b0, '0);
    add_row(ds2fd_pkg::IN_EOC,  8'h00, 1'b1,
            status_of(ds2fd_pkg::RK_TRUNC, 8'hB8, 1'b0, 8'd38));
    // Minimal short frame with a wrong checksum.
    add_row(ds2fd_pkg::IN_BYTE, 8'hFF, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h03, 1'b0, '0);
    add_row(ds2fd_pkg::IN_BYTE, 8'h00, 1'b1,
            status_of(ds2fd_pkg::RK_BADSUM, 8'hFF, 1'b0, 8'd0));
    add_row(ds2fd_pkg::IN_EOC,  8'h00, 1'b0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].want);

    // Four pressure phases: free running, sender gaps, receiver stalls, both.
    // Drain all results at each phase change.
    start_count = live_requests;
    cur_phase   = 0;
    while (live_requests - start_count < RANDOM_REQUESTS) begin
      phase = (live_requests - start_count) * 4 / RANDOM_REQUESTS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        drain_results();
        case (cur_phase)
          1:       begin send_idle_pct = 71; stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  stall_pct = 71; end
          default: begin send_idle_pct = 29; stall_pct = 29; end
        endcase
      end
      send_random_frame();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d requests (%0d acted on) across four gap/stall phases",
             sent_requests, live_requests);
    $display("checked %0d results: payload %0d, ok %0d, bad sum %0d, bad len %0d, trunc %0d",
             results_checked, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
             kinds_seen[4]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
